/* hw/rtl/bpc_pkg.sv */
// Shared types, constants and helpers for the barometer compensation pipeline.
// No dependencies; every module of the block imports this package.

package bpc_pkg;

    // Register map of the coefficient port
    typedef enum logic [2:0] {
        CFG_SENS     = 3'd0,
        CFG_OFF      = 3'd1,
        CFG_TCS      = 3'd2,
        CFG_TCO      = 3'd3,
        CFG_TREF     = 3'd4,
        CFG_TEMPSENS = 3'd5
    } cfg_idx_t;

    // Temperature thresholds, centidegrees C
    localparam logic signed [19:0] TEMP_BASE   = 20'sd2000;
    // temp < -15.00 C  <=>  (temp - 20.00 C) < -3500
    localparam logic signed [18:0] COLD_Q      = -19'sd3500;
    localparam logic signed [19:0] COLD_OFS    = 20'sd3500;
    localparam logic signed [21:0] KELVIN_OFS  = 22'sd27315;

    // Factory coefficients
    typedef struct packed {
        logic [15:0] sens;
        logic [15:0] off;
        logic [15:0] tcs;
        logic [15:0] tco;
        logic [15:0] tref;
        logic [15:0] tempsens;
    } coef_t;

    // First-order results
    typedef struct packed {
        logic        [23:0] d1;
        logic signed [18:0] q;      // temp - 2000
        logic signed [19:0] vlo;    // temp + 1500
        logic signed [35:0] off1;
        logic signed [35:0] sens1;
        logic        [17:0] t2;
    } first_t;

    // Corrected offset, sensitivity and temperature
    typedef struct packed {
        logic        [23:0] d1;
        logic signed [45:0] off;
        logic signed [45:0] sens;
        logic signed [20:0] temp_c;
    } comp_t;

    // Arithmetic shift right that rounds toward zero
    function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] x,
                                                     input int unsigned k);
        logic signed [63:0] bias;
        bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (x + bias) >>> k;
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (x < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = $signed(x[31:0]);
        return r;
    endfunction

endpackage

/* hw/rtl/bpc_front.sv */
// First-order stages 1..3: temperature difference, the four dT products and
// the truncating scaling into temp, OFF and SENS. Depends on bpc_pkg.

module bpc_front
    import bpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  coef_t       coef,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] raw_pressure,
    input  logic [23:0] raw_temperature,
    output logic        out_valid,
    input  logic        out_ready,
    output first_t      out_word
);

    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;

    logic        [23:0] d1_s1_reg, d1_s1_next;
    logic signed [24:0] dt_reg, dt_next;
    logic signed [25:0] dt_wide;

    logic        [23:0] d1_s2_reg, d1_s2_next;
    logic signed [41:0] mt_reg, mt_next;
    logic signed [41:0] mo_reg, mo_next;
    logic signed [41:0] ms_reg, ms_next;
    logic        [48:0] dsq_reg, dsq_next;
    logic signed [49:0] dsq_full;

    first_t             s3_reg, s3_next;
    logic signed [63:0] q_full, off_full, sens_full;

    // Ready ripples back: a stage takes a word when empty or when it drains
    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    // Stage 1: dT = D2 - C5*256
    always_comb
    begin
        dt_wide    = $signed({2'b00, raw_temperature}) - $signed({2'b00, coef.tref, 8'h00});
        dt_next    = dt_wide[24:0];
        d1_s1_next = raw_pressure;
    end

    // Stage 2: products with dT
    always_comb
    begin
        mt_next    = dt_reg * $signed({1'b0, coef.tempsens});
        mo_next    = dt_reg * $signed({1'b0, coef.tco});
        ms_next    = dt_reg * $signed({1'b0, coef.tcs});
        dsq_full   = dt_reg * dt_reg;
        dsq_next   = dsq_full[48:0];
        d1_s2_next = d1_s1_reg;
    end

    // Stage 3: scale toward zero, add the base terms
    always_comb
    begin
        q_full    = shr_trunc(64'(mt_reg), 23);
        off_full  = $signed({32'h0, coef.off, 16'h0000}) + shr_trunc(64'(mo_reg), 7);
        sens_full = $signed({33'h0, coef.sens, 15'h0000}) + shr_trunc(64'(ms_reg), 8);
        s3_next.d1    = d1_s2_reg;
        s3_next.q     = q_full[18:0];
        s3_next.vlo   = {q_full[18], q_full[18:0]} + COLD_OFS;
        s3_next.off1  = off_full[35:0];
        s3_next.sens1 = sens_full[35:0];
        s3_next.t2    = dsq_reg[48:31];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            d1_s1_reg <= d1_s1_next;
            dt_reg    <= dt_next;
        end
        if (r2)
        begin
            d1_s2_reg <= d1_s2_next;
            mt_reg    <= mt_next;
            mo_reg    <= mo_next;
            ms_reg    <= ms_next;
            dsq_reg   <= dsq_next;
        end
        if (r3)
            s3_reg <= s3_next;
    end

    assign out_valid = v3_reg;
    assign out_word  = s3_reg;

    // A stalled stage-3 word stays put
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !out_ready) |=> (v3_reg && $stable(s3_reg)))
        else $error("front stage 3 word lost under stall");

endmodule

/* hw/rtl/bpc_second.sv */
// Second-order correction, stages 4..6: squares of the low-temperature
// distances, the OFF2/SENS2 terms and their subtraction. Depends on bpc_pkg.

module bpc_second
    import bpc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  first_t in_word,
    output logic   out_valid,
    input  logic   out_ready,
    output comp_t  out_word
);

    typedef struct packed {
        logic        [23:0] d1;
        logic               neg1;
        logic               neg2;
        logic        [36:0] sq_lo;
        logic        [38:0] sq_v;
        logic signed [35:0] off1;
        logic signed [35:0] sens1;
        logic        [17:0] t2;
        logic signed [19:0] temp_c;
    } sq_t;

    typedef struct packed {
        logic        [23:0] d1;
        logic               neg1;
        logic        [43:0] off2;
        logic        [43:0] sens2;
        logic signed [35:0] off1;
        logic signed [35:0] sens1;
        logic        [17:0] t2;
        logic signed [19:0] temp_c;
    } corr_t;

    logic v4_reg, v5_reg, v6_reg;
    logic r4, r5, r6;

    sq_t                s4_reg, s4_next;
    corr_t              s5_reg, s5_next;
    comp_t              s6_reg, s6_next;
    logic signed [37:0] sq_lo_full;
    logic signed [39:0] sq_v_full;
    logic        [43:0] lo5, v7, v11;

    assign r6       = !v6_reg || out_ready;
    assign r5       = !v5_reg || r6;
    assign r4       = !v4_reg || r5;
    assign in_ready = r4;

    // Stage 4: squares and the cold flags
    always_comb
    begin
        sq_lo_full     = in_word.q * in_word.q;
        sq_v_full      = in_word.vlo * in_word.vlo;
        s4_next.d1     = in_word.d1;
        s4_next.neg1   = in_word.q[18];
        s4_next.neg2   = in_word.q < COLD_Q;
        s4_next.sq_lo  = sq_lo_full[36:0];
        s4_next.sq_v   = sq_v_full[38:0];
        s4_next.off1   = in_word.off1;
        s4_next.sens1  = in_word.sens1;
        s4_next.t2     = in_word.t2;
        s4_next.temp_c = {in_word.q[18], in_word.q} + TEMP_BASE;
    end

    // Stage 5: OFF2 and SENS2 by shift-and-add
    always_comb
    begin
        lo5 = {5'h0, s4_reg.sq_lo, 2'b00} + {7'h0, s4_reg.sq_lo};
        v7  = {2'b00, s4_reg.sq_v, 3'b000} - {5'h0, s4_reg.sq_v};
        v11 = {2'b00, s4_reg.sq_v, 3'b000} + {4'h0, s4_reg.sq_v, 1'b0}
            + {5'h0, s4_reg.sq_v};
        s5_next.d1     = s4_reg.d1;
        s5_next.neg1   = s4_reg.neg1;
        s5_next.off2   = (lo5 >> 1) + (s4_reg.neg2 ? v7 : 44'h0);
        s5_next.sens2  = (lo5 >> 2) + (s4_reg.neg2 ? (v11 >> 1) : 44'h0);
        s5_next.off1   = s4_reg.off1;
        s5_next.sens1  = s4_reg.sens1;
        s5_next.t2     = s4_reg.t2;
        s5_next.temp_c = s4_reg.temp_c;
    end

    // Stage 6: apply the correction below 20.00 C
    always_comb
    begin
        s6_next.d1     = s5_reg.d1;
        s6_next.off    = {{10{s5_reg.off1[35]}}, s5_reg.off1}
                       - (s5_reg.neg1 ? $signed({2'b00, s5_reg.off2}) : 46'sd0);
        s6_next.sens   = {{10{s5_reg.sens1[35]}}, s5_reg.sens1}
                       - (s5_reg.neg1 ? $signed({2'b00, s5_reg.sens2}) : 46'sd0);
        s6_next.temp_c = {s5_reg.temp_c[19], s5_reg.temp_c}
                       - (s5_reg.neg1 ? $signed({3'b000, s5_reg.t2}) : 21'sd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (r4) v4_reg <= in_valid;
            if (r5) v5_reg <= v4_reg;
            if (r6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r4) s4_reg <= s4_next;
        if (r5) s5_reg <= s5_next;
        if (r6) s6_reg <= s6_next;
    end

    assign out_valid = v6_reg;
    assign out_word  = s6_reg;

    // Very cold is a subset of cold
    a_cold_subset: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && s4_reg.neg2) |-> s4_reg.neg1)
        else $error("extra cold term flagged above 20.00 C");

    // Above 20.00 C the offset passes through unchanged
    a_warm_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && r6 && !s5_reg.neg1)
            |=> (s6_reg.off == {{10{$past(s5_reg.off1[35])}}, $past(s5_reg.off1)}))
        else $error("offset corrected above 20.00 C");

endmodule

/* hw/rtl/bpc_pressure.sv */
// Pressure stages 7..10: D1*SENS as two partial products, recombination,
// scaling with OFF, saturation of both outputs. Depends on bpc_pkg.

module bpc_pressure
    import bpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  comp_t              in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pressure_pascal,
    output logic signed [31:0] temperature_centikelvin
);

    logic v7_reg, v8_reg, v9_reg, v10_reg;
    logic r7, r8, r9, r10;

    // Stage 7
    logic        [46:0] pp_lo_reg, pp_lo_next;
    logic signed [47:0] pp_hi_reg, pp_hi_next;
    logic signed [45:0] off7_reg;
    logic signed [20:0] temp7_reg;
    // Stage 8
    logic signed [63:0] prod_reg, prod_next;
    logic signed [45:0] off8_reg;
    logic signed [21:0] tempk8_reg, tempk8_next;
    // Stage 9
    logic signed [63:0] acc_reg, acc_next;
    logic signed [21:0] tempk9_reg;
    // Stage 10
    logic signed [31:0] press_reg, press_next;
    logic signed [31:0] tempk_reg, tempk_next;

    assign r10      = !v10_reg || out_ready;
    assign r9       = !v9_reg || r10;
    assign r8       = !v8_reg || r9;
    assign r7       = !v7_reg || r8;
    assign in_ready = r7;

    // Stage 7: split SENS at bit 23, two products of at most 25x23 bits
    always_comb
    begin
        pp_lo_next = {23'h0, in_word.d1} * {24'h0, in_word.sens[22:0]};
        pp_hi_next = $signed({1'b0, in_word.d1}) * $signed(in_word.sens[45:23]);
    end

    // Stage 8: recombine, form kelvin
    always_comb
    begin
        prod_next   = (64'(pp_hi_reg) <<< 23) + $signed({17'h0, pp_lo_reg});
        tempk8_next = {temp7_reg[20], temp7_reg} + KELVIN_OFS;
    end

    // Stage 9: D1*SENS/2^21 - OFF
    always_comb
    begin
        acc_next = shr_trunc(prod_reg, 21) - 64'(off8_reg);
    end

    // Stage 10: /2^15 and clamp
    always_comb
    begin
        press_next = sat32(shr_trunc(acc_reg, 15));
        tempk_next = sat32(64'(tempk9_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end
        else
        begin
            if (r7)  v7_reg  <= in_valid;
            if (r8)  v8_reg  <= v7_reg;
            if (r9)  v9_reg  <= v8_reg;
            if (r10) v10_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r7)
        begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
            off7_reg  <= in_word.off;
            temp7_reg <= in_word.temp_c;
        end
        if (r8)
        begin
            prod_reg   <= prod_next;
            off8_reg   <= off7_reg;
            tempk8_reg <= tempk8_next;
        end
        if (r9)
        begin
            acc_reg    <= acc_next;
            tempk9_reg <= tempk8_reg;
        end
        if (r10)
        begin
            press_reg <= press_next;
            tempk_reg <= tempk_next;
        end
    end

    assign out_valid               = v10_reg;
    assign pressure_pascal         = press_reg;
    assign temperature_centikelvin = tempk_reg;

    // A word in stage 9 moves on whenever the output stage can take it
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (v9_reg && r10) |=> v10_reg)
        else $error("stage 9 word dropped on advance");

    // A blocked stage 9 word is kept intact
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v9_reg && !r10) |=> (v9_reg && $stable(acc_reg) && $stable(tempk9_reg)))
        else $error("stage 9 word changed while blocked");

endmodule

/* hw/rtl/barometer_pressure_compensation_top.sv */
// Top level of the barometer compensation block: coefficient registers and
// the three pipeline sections. Depends on bpc_pkg, bpc_front, bpc_second, bpc_pressure.
//
//  Channel   Signals                                         Direction
//  config    cfg_valid cfg_ready cfg_index[2:0] cfg_data[15:0]  in (ready out)
//  sample    sample_valid sample_ready raw_pressure raw_temperature  in
//  result    result_valid result_ready pressure_pascal
//            temperature_centikelvin                          out
//
// Ten register stages; one sample word is taken per cycle when the result side
// keeps up; results leave in the order the samples were taken.
// Reset clears the valid bits and sets all six coefficients to zero.
// A stalled result holds every stage that is full; empty stages still fill,
// so bubbles are squeezed out. cfg_ready is always high; indexes 6 and 7 are ignored.

module barometer_pressure_compensation_top
    import bpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  logic [23:0]        raw_pressure,
    input  logic [23:0]        raw_temperature,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [31:0] pressure_pascal,
    output logic signed [31:0] temperature_centikelvin
);

    coef_t  coef_reg, coef_next;
    logic   fr_valid, fr_ready, sc_valid, sc_ready;
    first_t fr_word;
    comp_t  sc_word;

    assign cfg_ready = 1'b1;

    // Coefficient register write decode
    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SENS:     coef_next.sens     = cfg_data;
                CFG_OFF:      coef_next.off      = cfg_data;
                CFG_TCS:      coef_next.tcs      = cfg_data;
                CFG_TCO:      coef_next.tco      = cfg_data;
                CFG_TREF:     coef_next.tref     = cfg_data;
                CFG_TEMPSENS: coef_next.tempsens = cfg_data;
                default:      coef_next          = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coef_reg <= '0;
        else
            coef_reg <= coef_next;
    end

    bpc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .coef            (coef_reg),
        .in_valid        (sample_valid),
        .in_ready        (sample_ready),
        .raw_pressure    (raw_pressure),
        .raw_temperature (raw_temperature),
        .out_valid       (fr_valid),
        .out_ready       (fr_ready),
        .out_word        (fr_word)
    );

    bpc_second u_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_word   (fr_word),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .out_word  (sc_word)
    );

    bpc_pressure u_pressure (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .in_valid                (sc_valid),
        .in_ready                (sc_ready),
        .in_word                 (sc_word),
        .out_valid               (result_valid),
        .out_ready               (result_ready),
        .pressure_pascal         (pressure_pascal),
        .temperature_centikelvin (temperature_centikelvin)
    );

endmodule

/* verif/tb_barometer_pressure_compensation_top.sv */
// Testbench for barometer_pressure_compensation_top: random and directed sample words
// checked against a cycle-free predictor of the second-order compensation.
// Depends on bpc_pkg (register index enum) and the RTL of the block.

module tb_barometer_pressure_compensation_top
    import bpc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Unused register indexes, written to prove they are ignored
    localparam logic [2:0]  CFG_SPARE_LO = 3'd6;
    localparam logic [2:0]  CFG_SPARE_HI = 3'd7;

    localparam logic [23:0] RAW_MAX      = 24'hFF_FFFF;
    localparam int          RAW_TOP      = 16777215;

    // Compensation scale factors (all powers of two), temperature constants, int32 limits
    localparam longint DIV_TEMP   = 64'sd8388608;      // 2^23
    localparam longint DIV_T2     = 64'sd2147483648;   // 2^31
    localparam longint DIV_SENS   = 64'sd2097152;      // 2^21
    localparam longint DIV_PRES   = 64'sd32768;        // 2^15
    localparam longint WARM_EDGE  = 64'sd2000;         // 20.00 C
    localparam longint COLD_EDGE  = -64'sd1500;        // -15.00 C
    localparam longint KELVIN_OFS = 64'sd27315;
    localparam longint I32_MAX    = 64'sd2147483647;
    localparam longint I32_MIN    = -64'sd2147483648;

    localparam int CYCLE_LIMIT = 1000000;

    typedef enum int {IDLE_RANDOM, IDLE_NONE, IDLE_LIGHT} idle_mode_t;

    typedef struct packed {
        logic        [23:0] raw_p;
        logic        [23:0] raw_t;
        logic signed [31:0] pressure;
        logic signed [31:0] temp;
    } reading_t;

    // Coefficient mirror, compensation predictor and queue of pending readings
    class compensation_checker;
        longint   coef [6];
        reading_t expected_readings [$];
        int       error_count;

        function void set_coefficient(logic [2:0] idx, logic [15:0] value);
            if (idx <= CFG_TEMPSENS)
                coef[idx] = {48'd0, value};
        endfunction

        function logic signed [31:0] clamp32(longint v);
            if (v > I32_MAX)
                return 32'sh7FFF_FFFF;
            else if (v < I32_MIN)
                return 32'sh8000_0000;
            return v[31:0];
        endfunction

        function void predict_reading(logic [23:0] raw_p, logic [23:0] raw_t);
            longint   d1, d2, dt, temp, off, sens, p;
            longint   t2, lo, off2, sens2, vlo;
            reading_t r;
            d1 = {40'd0, raw_p};
            d2 = {40'd0, raw_t};
            dt = d2 - coef[CFG_TREF] * 256;
            temp = WARM_EDGE + (dt * coef[CFG_TEMPSENS]) / DIV_TEMP;
            off  = coef[CFG_OFF] * 65536 + (coef[CFG_TCO] * dt) / 128;
            sens = coef[CFG_SENS] * 32768 + (coef[CFG_TCS] * dt) / 256;
            // second-order terms below 20 C, extra terms below -15 C
            if (temp < WARM_EDGE)
            begin
                t2    = (dt * dt) / DIV_T2;
                lo    = temp - WARM_EDGE;
                off2  = (5 * lo * lo) / 2;
                sens2 = (5 * lo * lo) / 4;
                if (temp < COLD_EDGE)
                begin
                    vlo   = temp - COLD_EDGE;
                    off2  += 7 * vlo * vlo;
                    sens2 += (11 * vlo * vlo) / 2;
                end
                temp -= t2;
                off  -= off2;
                sens -= sens2;
            end
            p = ((d1 * sens) / DIV_SENS - off) / DIV_PRES;
            r.raw_p    = raw_p;
            r.raw_t    = raw_t;
            r.pressure = clamp32(p);
            r.temp     = clamp32(temp + KELVIN_OFS);
            expected_readings.push_back(r);
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function void flag(string msg);
            error_count++;
            if (error_count <= 10)
                $display("%s", msg);
        endfunction

        function void check_reading(logic signed [31:0] p, logic signed [31:0] t);
            reading_t r;
            if (expected_readings.size() == 0)
            begin
                flag($sformatf("unexpected result word: pressure %0d, temperature %0d",
                               p, t));
                return;
            end
            r = expected_readings.pop_front();
            if (p !== r.pressure)
                flag($sformatf("pressure_pascal mismatch (raw %h/%h): expected %0d, got %0d",
                               r.raw_p, r.raw_t, r.pressure, p));
            if (t !== r.temp)
                flag($sformatf("temperature_centikelvin mismatch (raw %h/%h): expected %0d, got %0d",
                               r.raw_p, r.raw_t, r.temp, t));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = CFG_SENS;
    logic [15:0]        cfg_data = 16'd0;
    logic               sample_valid = 1'b0;
    logic               sample_ready;
    logic [23:0]        raw_pressure = 24'd0;
    logic [23:0]        raw_temperature = 24'd0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic signed [31:0] pressure_pascal;
    logic signed [31:0] temperature_centikelvin;

    compensation_checker sb;
    idle_mode_t          tx_mode = IDLE_RANDOM;
    idle_mode_t          rx_mode = IDLE_RANDOM;
    int                  hold_cycles = 0;
    int                  rx_stall;
    int                  cycle_count = 0;

    barometer_pressure_compensation_top dut (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cfg_valid               (cfg_valid),
        .cfg_ready               (cfg_ready),
        .cfg_index               (cfg_index),
        .cfg_data                (cfg_data),
        .sample_valid            (sample_valid),
        .sample_ready            (sample_ready),
        .raw_pressure            (raw_pressure),
        .raw_temperature         (raw_temperature),
        .result_valid            (result_valid),
        .result_ready            (result_ready),
        .pressure_pascal         (pressure_pascal),
        .temperature_centikelvin (temperature_centikelvin)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("barometer_pressure_compensation_top test failed");
            $finish;
        end
    end

    // Handshake monitor: values seen here are the ones before this edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
                sb.set_coefficient(cfg_index, cfg_data);
            if (sample_valid === 1'b1 && sample_ready === 1'b1)
                sb.predict_reading(raw_pressure, raw_temperature);
            if (result_valid === 1'b1 && result_ready === 1'b1)
                sb.check_reading(pressure_pascal, temperature_centikelvin);
        end
    end

    function automatic int draw_gap(idle_mode_t m);
        case (m)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
            default:    return $urandom_range(0, 16);
        endcase
    endfunction

    function automatic logic [15:0] draw_coefficient();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Result side: random stall per word, plus a long hold when requested
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                rx_stall = hold_cycles;
                hold_cycles = 0;
            end
            else
                rx_stall = draw_gap(rx_mode);
            if (rx_stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (rx_stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!(result_valid === 1'b1 && result_ready === 1'b1));
        end
    end

    // Offer one sample word; valid stays high across back-to-back words
    task automatic offer_sample(input logic [23:0] p, input logic [23:0] t);
        int gap;
        gap = draw_gap(tx_mode);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid    <= 1'b1;
        raw_pressure    <= p;
        raw_temperature <= t;
        do @(posedge clk); while (sample_ready !== 1'b1);
    endtask

    task automatic write_coefficient(input logic [2:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
    endtask

    task automatic load_coefficients(input logic [15:0] vals [6], input bit touch_spare);
        int k;
        for (k = 0; k < 6; k++)
            write_coefficient(cfg_idx_t'(k), vals[k]);
        if (touch_spare)
        begin
            write_coefficient(CFG_SPARE_LO, 16'hFFFF);
            write_coefficient(CFG_SPARE_HI, 16'h5A5A);
        end
        cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait until every pending reading has come back
    task automatic settle_pipeline();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic run_random_phase(input int count, input int hold);
        logic [15:0] vals [6];
        logic [23:0] p, t;
        int          k, n, center, near;
        for (k = 0; k < 6; k++)
            vals[k] = draw_coefficient();
        load_coefficients(vals, 1'b0);
        tx_mode = idle_mode_t'($urandom_range(0, 2));
        rx_mode = idle_mode_t'($urandom_range(0, 2));
        // long result stall while the sender keeps pushing
        if (hold > 0)
            tx_mode = IDLE_LIGHT;
        hold_cycles = hold;
        center = int'(vals[CFG_TREF]) * 256;
        for (n = 0; n < count; n++)
        begin
            p = 24'($urandom_range(0, RAW_TOP));
            // a quarter of the words sit near the reference temperature
            if ($urandom_range(0, 3) == 0)
            begin
                near = center + int'($urandom_range(0, 131072)) - 65536;
                if (near < 0)
                    near = 0;
                else if (near > RAW_TOP)
                    near = RAW_TOP;
                t = near[23:0];
            end
            else
                t = 24'($urandom_range(0, RAW_TOP));
            offer_sample(p, t);
        end
        settle_pipeline();
    endtask

    // Main sequence
    initial
    begin
        logic [15:0] coefs [6];
        int          ph;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coefficients still at reset (all zero)
        offer_sample(24'd0, 24'd0);
        offer_sample(RAW_MAX, RAW_MAX);
        offer_sample(RAW_MAX, 24'd0);
        offer_sample(24'd0, RAW_MAX);
        settle_pipeline();

        // typical factory calibration, spare indexes written too
        coefs = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
        load_coefficients(coefs, 1'b1);
        offer_sample(24'd9085466, 24'd8569150);
        offer_sample(24'd0, 24'd0);
        offer_sample(RAW_MAX, RAW_MAX);
        offer_sample(RAW_MAX, 24'd0);
        offer_sample(24'd0, RAW_MAX);
        offer_sample(24'd9085466, 24'd8566784);   // exactly 20.00 C
        offer_sample(24'd9085466, 24'd8566487);   // just below 20.00 C
        offer_sample(24'd9085466, 24'd7529762);   // exactly -15.00 C
        offer_sample(24'd9085466, 24'd7529466);   // just below -15.00 C
        settle_pipeline();

        // all coefficients at full scale
        coefs = '{default: 16'hFFFF};
        load_coefficients(coefs, 1'b0);
        offer_sample(24'd0, 24'd0);
        offer_sample(RAW_MAX, RAW_MAX);
        offer_sample(RAW_MAX, 24'd0);
        offer_sample(24'd0, RAW_MAX);
        settle_pipeline();

        // all coefficients written back to zero
        coefs = '{default: 16'h0000};
        load_coefficients(coefs, 1'b0);
        offer_sample(RAW_MAX, RAW_MAX);
        offer_sample(24'd123456, 24'd7654321);
        settle_pipeline();

        // random coefficient sets; phase 3 holds the result side off for long
        for (ph = 0; ph < 8; ph++)
            run_random_phase(238, (ph == 3) ? 400 : 0);

        repeat (20) @(posedge clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("barometer_pressure_compensation_top test passed");
        else
            $display("barometer_pressure_compensation_top test failed");
        $finish;
    end

endmodule
